// ----- rtl/base64_strict_decoder_core_macros.svh -----
// Assertion macros for the base64 strict decoder core.
// Included by the top level; no dependencies.
`ifndef BASE64_STRICT_DECODER_CORE_MACROS_SVH
`define BASE64_STRICT_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define B64SD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define B64SD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/b64sd_pkg.sv -----
// Shared types, constants and the alphabet lookup for the base64 strict decoder.
// No dependencies.
package b64sd_pkg;

	localparam int FIFO_DEPTH_DEF = 4;

	typedef enum logic [2:0] {
		ST_OK              = 3'd0,
		ST_BAD_CHAR        = 3'd1,
		ST_CHAR_AFTER_PAD  = 3'd2,
		ST_AFTER_FINAL_PAD = 3'd3,
		ST_TOO_MANY_PADS   = 3'd4,
		ST_INCOMPLETE      = 3'd5
	} status_t;

	localparam logic [7:0] CH_PAD   = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// one queued job: up to three bytes and an optional final status
	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  nbytes;
		logic        has_status;
		status_t     status;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// {valid, sextet}
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		end else if (c == CH_PLUS) begin
			r = {1'b1, 6'd62};
		end else if (c == CH_SLASH) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

// ----- rtl/b64sd_in_if.sv -----
// Input channel: per item, an optional character and an optional end marker.
// Depends on nothing.
interface b64sd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       has_char;
	logic       end_of_text;

	modport source (output valid, char_code, has_char, end_of_text, input ready);
	modport sink (input valid, char_code, has_char, end_of_text, output ready);
endinterface

// ----- rtl/b64sd_out_if.sv -----
// Output channel: one decoded byte or final status per item.
// Depends on nothing.
interface b64sd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_status;
	logic [2:0] status_code;
	logic       last_result;

	modport source (output valid, out_byte, is_status, status_code, last_result, input ready);
	modport sink (input valid, out_byte, is_status, status_code, last_result, output ready);
endinterface

// ----- rtl/b64sd_front.sv -----
// Front end: accepts characters, tracks group and error state, builds queue entries.
// Depends on b64sd_pkg.
module b64sd_front import b64sd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	b64sd_in_if.sink   chars,
	input  fifo_stat_t fstat,
	output logic       push,
	output entry_t     push_entry
);

	logic [17:0] held_q, held_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [1:0]  pads_q, pads_d;
	logic        padst_q, padst_d;
	logic        fps_q, fps_d;
	status_t     err_q, err_d;

	logic        accept;
	logic        is_ws;
	logic        is_pad;
	logic [6:0]  sx;
	logic [5:0]  value;
	logic [2:0]  pads_tot;
	logic [1:0]  nbytes;

	assign chars.ready = !fstat.full;
	assign accept = chars.valid && chars.ready;

	always_comb begin
		is_ws  = (chars.char_code == CH_SPACE) ||
			(chars.char_code >= 8'h09 && chars.char_code <= 8'h0D);
		is_pad = (chars.char_code == CH_PAD);
		sx     = sextet_of(chars.char_code);
		value  = is_pad ? 6'd0 : sx[5:0];
		pads_tot = {1'b0, pads_q} + {2'b00, is_pad};

		held_d  = held_q;
		cnt_d   = cnt_q;
		pads_d  = pads_q;
		padst_d = padst_q;
		fps_d   = fps_q;
		err_d   = err_q;
		nbytes  = 2'd0;

		if (chars.has_char && !is_ws && err_q == ST_OK) begin
			if (fps_q) begin
				err_d = ST_AFTER_FINAL_PAD;
			end else if (!is_pad && padst_q) begin
				err_d = ST_CHAR_AFTER_PAD;
			end else if (!is_pad && !sx[6]) begin
				err_d = ST_BAD_CHAR;
			end else if (cnt_q != 2'd3) begin
				held_d = {held_q[11:0], value};
				cnt_d  = cnt_q + 2'd1;
				if (is_pad) begin
					padst_d = 1'b1;
					pads_d  = pads_q + 2'd1;
				end
			end else if (pads_tot > 3'd2) begin
				err_d = ST_TOO_MANY_PADS;
			end else begin
				nbytes  = 2'(3'd3 - pads_tot);
				fps_d   = (pads_tot != 3'd0);
				held_d  = '0;
				cnt_d   = 2'd0;
				pads_d  = 2'd0;
				padst_d = 1'b0;
			end
		end

		push_entry.word       = {held_q, value};
		push_entry.nbytes     = nbytes;
		push_entry.has_status = chars.end_of_text;
		if (err_d != ST_OK) begin
			push_entry.status = err_d;
		end else if (cnt_d != 2'd0) begin
			push_entry.status = ST_INCOMPLETE;
		end else begin
			push_entry.status = ST_OK;
		end
		push = accept && (nbytes != 2'd0 || chars.end_of_text);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			cnt_q   <= '0;
			pads_q  <= '0;
			padst_q <= 1'b0;
			fps_q   <= 1'b0;
			err_q   <= ST_OK;
		end else if (accept) begin
			if (chars.end_of_text) begin
				held_q  <= '0;
				cnt_q   <= '0;
				pads_q  <= '0;
				padst_q <= 1'b0;
				fps_q   <= 1'b0;
				err_q   <= ST_OK;
			end else begin
				held_q  <= held_d;
				cnt_q   <= cnt_d;
				pads_q  <= pads_d;
				padst_q <= padst_d;
				fps_q   <= fps_d;
				err_q   <= err_d;
			end
		end
	end

endmodule

// ----- rtl/b64sd_fifo.sv -----
// Short queue of decode entries between front and back end.
// Depends on b64sd_pkg.
module b64sd_fifo import b64sd_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  entry_t     push_entry,
	input  logic       pop,
	output entry_t     head,
	output fifo_stat_t fstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign fstat.full  = (count_q == CW'(DEPTH));
	assign fstat.empty = (count_q == '0);
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/b64sd_back.sv -----
// Back end: walks each queue entry and issues bytes then status into an output register.
// Depends on b64sd_pkg.
module b64sd_back import b64sd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     head,
	input  fifo_stat_t fstat,
	output logic       pop,
	b64sd_out_if.source results
);

	logic [1:0] pos_q;
	logic       load;
	logic [2:0] total;
	logic       last;
	logic       is_data;
	logic [7:0] sel_byte;

	always_comb begin
		total   = {1'b0, head.nbytes} + {2'b00, head.has_status};
		last    = ({1'b0, pos_q} + 3'd1 == total);
		is_data = (pos_q < head.nbytes);
		case (pos_q)
			2'd0:    sel_byte = head.word[23:16];
			2'd1:    sel_byte = head.word[15:8];
			default: sel_byte = head.word[7:0];
		endcase
		load = !fstat.empty && (!results.valid || results.ready);
		pop  = load && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.valid <= 1'b0;
			pos_q         <= '0;
		end else begin
			if (load) begin
				results.valid <= 1'b1;
				pos_q         <= last ? 2'd0 : pos_q + 2'd1;
			end else if (results.ready) begin
				results.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			results.out_byte    <= is_data ? sel_byte : 8'd0;
			results.is_status   <= !is_data;
			results.status_code <= is_data ? ST_OK : head.status;
			results.last_result <= last;
		end
	end

endmodule

// ----- rtl/base64_strict_decoder_core.sv -----
// Channel   Dir  Payload                                          Handshake
// chars     in   char_code, has_char, end_of_text                 valid/ready
// results   out  out_byte, is_status, status_code, last_result    valid/ready
//
// One character is accepted per cycle while the entry queue has room.
// A group gives up to three bytes plus a status at the end marker. The back end issues
// one result per cycle while results is ready, which bounds sustained output.
// Items pass the entry queue, then the output register. Reset clears all but data storage.
// Depends on b64sd_pkg, b64sd_in_if, b64sd_out_if, front, fifo, back and the macro header.
`include "base64_strict_decoder_core_macros.svh"

module base64_strict_decoder_core import b64sd_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	b64sd_in_if.sink     chars,
	b64sd_out_if.source  results
);

	fifo_stat_t fstat;
	logic       push;
	logic       pop;
	entry_t     push_entry;
	entry_t     head;

	b64sd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.fstat      (fstat),
		.push       (push),
		.push_entry (push_entry)
	);

	b64sd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.fstat      (fstat)
	);

	b64sd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.fstat   (fstat),
		.pop     (pop),
		.results (results)
	);

	`B64SD_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !fstat.full, "push into full queue")
	`B64SD_ASSERT_NOW(a_status_last, clk, arst_n, results.valid && results.is_status, results.last_result, "status not last")
	`B64SD_ASSERT_NOW(a_data_code_ok, clk, arst_n, results.valid && !results.is_status, results.status_code == ST_OK, "data item with status code")
	`B64SD_ASSERT_NEXT(a_end_push, clk, arst_n, chars.valid && chars.ready && chars.end_of_text, !fstat.empty, "end marker lost")

endmodule

// ----- tb/sv/tb_base64_strict_decoder_core.sv -----
`timescale 1ns / 100ps
// Testbench for base64_strict_decoder_core: directed and random texts, random stalls on both
// channels, results checked in order against a built-in decoder. Needs b64sd_pkg, b64sd_in_if,
// b64sd_out_if and the core.
module tb_base64_strict_decoder_core;
	import b64sd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       is_status;
		status_t    code;
		logic       last;
	} b64_result_t;

	class b64_decode_board;
		logic [17:0]   held = '0;
		int            group_len = 0;
		int            pad_len = 0;
		bit            pad_open = 0;
		bit            closed_by_pad = 0;
		status_t       first_error = ST_OK;
		b64_result_t   pending_results[$];
		int            mismatches = 0;

		function void take_item(logic [7:0] c, logic has, logic eot);
			b64_result_t fresh[$];
			b64_result_t r;
			logic [5:0]  value;
			logic [23:0] word;
			bit          is_pad;
			bit          known;
			bit          blank;
			int          total_pads;
			is_pad = (c == CH_PAD);
			blank = (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
			known = 1'b1;
			value = '0;
			if (c >= 8'h41 && c <= 8'h5A) begin
				value = 6'(int'(c) - 'h41);
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				value = 6'(int'(c) - 'h61 + 26);
			end else if (c >= 8'h30 && c <= 8'h39) begin
				value = 6'(int'(c) - 'h30 + 52);
			end else if (c == CH_PLUS) begin
				value = 6'd62;
			end else if (c == CH_SLASH) begin
				value = 6'd63;
			end else begin
				known = 1'b0;
			end

			if (has && !blank && first_error == ST_OK) begin
				total_pads = pad_len + (is_pad ? 1 : 0);
				if (closed_by_pad) begin
					first_error = ST_AFTER_FINAL_PAD;
				end else if (!is_pad && pad_open) begin
					first_error = ST_CHAR_AFTER_PAD;
				end else if (!is_pad && !known) begin
					first_error = ST_BAD_CHAR;
				end else if (group_len < 3) begin
					held = {held[11:0], value};
					group_len++;
					if (is_pad) begin
						pad_open = 1'b1;
						pad_len++;
					end
				end else if (total_pads > 2) begin
					first_error = ST_TOO_MANY_PADS;
				end else begin
					word = {held, value};
					r = '{word[23:16], 1'b0, ST_OK, 1'b0};
					fresh = {fresh, r};
					if (total_pads < 2) begin
						r.data = word[15:8];
						fresh = {fresh, r};
					end
					if (total_pads < 1) begin
						r.data = word[7:0];
						fresh = {fresh, r};
					end
					if (total_pads > 0)
						closed_by_pad = 1'b1;
					held = '0;
					group_len = 0;
					pad_len = 0;
					pad_open = 1'b0;
				end
			end

			if (eot) begin
				r = '{8'h00, 1'b1, first_error, 1'b0};
				if (first_error == ST_OK && group_len != 0)
					r.code = ST_INCOMPLETE;
				fresh = {fresh, r};
				held = '0;
				group_len = 0;
				pad_len = 0;
				pad_open = 1'b0;
				closed_by_pad = 1'b0;
				first_error = ST_OK;
			end

			if (fresh.size() > 0)
				fresh[fresh.size() - 1].last = 1'b1;
			foreach (fresh[i])
				pending_results = {pending_results, fresh[i]};
		endfunction

		function void check_result(logic [7:0] d, logic st, logic [2:0] code, logic last);
			b64_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual byte %h status %b code %0d",
					$time, d, st, code);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (d !== want.data) begin
				$display("%0t: out_byte expected %h actual %h", $time, want.data, d);
				mismatches++;
			end
			if (st !== want.is_status) begin
				$display("%0t: is_status expected %b actual %b", $time, want.is_status, st);
				mismatches++;
			end
			if (code !== 3'(want.code)) begin
				$display("%0t: status_code expected %0d actual %0d", $time, want.code, code);
				mismatches++;
			end
			if (last !== want.last) begin
				$display("%0t: last_result expected %b actual %b", $time, want.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   steady_flow = 1'b0;
	int   fed_items = 0;

	b64_decode_board board = new();

	b64sd_in_if  chars();
	b64sd_out_if results();

	base64_strict_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.results(results)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		results.ready <= steady_flow || ($urandom_range(0, 99) >= 20);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (chars.valid && chars.ready)
				board.take_item(chars.char_code, chars.has_char, chars.end_of_text);
			if (results.valid && results.ready)
				board.check_result(results.out_byte, results.is_status, results.status_code,
					results.last_result);
		end
	end

	function automatic logic [7:0] alpha_char(int v);
		if (v < 26)
			return 8'(int'("A") + v);
		if (v < 52)
			return 8'(int'("a") + v - 26);
		if (v < 62)
			return 8'(int'("0") + v - 52);
		return (v == 62) ? CH_PLUS : CH_SLASH;
	endfunction

	// called and returns at a falling edge
	task automatic send_item(input logic [7:0] c, input logic has, input logic eot);
		while (!steady_flow && $urandom_range(0, 99) < 20) begin
			chars.valid <= 1'b0;
			@(negedge clk);
		end
		chars.valid <= 1'b1;
		chars.char_code <= c;
		chars.has_char <= has;
		chars.end_of_text <= eot;
		do @(posedge clk); while (!chars.ready);
		fed_items++;
		@(negedge clk);
	endtask

	task automatic send_random_text();
		logic [7:0] text[$];
		logic [7:0] blanks[6];
		int         groups;
		int         pads;
		int         extra;
		bit         glue_end;
		blanks = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		groups = $urandom_range(0, 3);
		for (int g = 0; g < groups; g++) begin
			pads = (g == groups - 1 && $urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
			for (int k = 0; k < 4; k++)
				text = {text, ((k >= 4 - pads) ? CH_PAD : alpha_char($urandom_range(0, 63)))};
		end
		if ($urandom_range(0, 4) == 0)
			text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 5) == 0) begin
			extra = $urandom_range(1, 3);
			repeat (extra) text = {text, alpha_char($urandom_range(0, 63))};
		end
		if ($urandom_range(0, 9) == 0)
			text = {text, CH_PAD};
		glue_end = (text.size() > 0) && ($urandom_range(0, 1) == 1);

		foreach (text[k]) begin
			if ($urandom_range(0, 7) == 0)
				send_item(blanks[$urandom_range(0, 5)], 1'b1, 1'b0);
			if ($urandom_range(0, 15) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(text[k], 1'b1, glue_end && (k == text.size() - 1));
		end
		if (!glue_end)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		chars.valid = 1'b0;
		chars.char_code = '0;
		chars.has_char = 1'b0;
		chars.end_of_text = 1'b0;
		results.ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// whitespace inside a group, end marker on the last character
		send_item("T", 1'b1, 1'b0);
		send_item("W", 1'b1, 1'b0);
		send_item(8'h0D, 1'b1, 1'b0);
		send_item("F", 1'b1, 1'b0);
		send_item("u", 1'b1, 1'b1);
		// character after a padded group
		send_item("T", 1'b1, 1'b0);
		send_item("Q", 1'b1, 1'b0);
		send_item(CH_PAD, 1'b1, 1'b0);
		send_item(CH_PAD, 1'b1, 1'b0);
		send_item("A", 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		// non-pad after pad within a group
		send_item("Q", 1'b1, 1'b0);
		send_item(CH_PAD, 1'b1, 1'b0);
		send_item("A", 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		// bad character, later ones ignored
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
		// three pads
		send_item("A", 1'b1, 1'b0);
		send_item(CH_PAD, 1'b1, 1'b0);
		send_item(CH_PAD, 1'b1, 1'b0);
		send_item(CH_PAD, 1'b1, 1'b1);
		// incomplete group
		send_item(CH_SLASH, 1'b1, 1'b0);
		send_item(CH_PLUS, 1'b1, 1'b1);
		// no character, no end; then an empty text
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(CH_SPACE, 1'b0, 1'b1);

		while (fed_items < 230) begin
			steady_flow = (fed_items >= 90 && fed_items < 150);
			send_random_text();
		end
		steady_flow = 1'b0;
		chars.valid <= 1'b0;

		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.mismatches == 0)
			$display("tb_base64_strict_decoder_core: done, clean");
		else
			$display("tb_base64_strict_decoder_core: done, errors");
		$finish;
	end

	initial begin
		#200000;
		$display("tb_base64_strict_decoder_core: done, errors");
		$finish;
	end

endmodule

// ----- base64_strict_decoder_core.f -----
+incdir+rtl
rtl/b64sd_pkg.sv
rtl/b64sd_in_if.sv
rtl/b64sd_out_if.sv
rtl/b64sd_front.sv
rtl/b64sd_fifo.sv
rtl/b64sd_back.sv
rtl/base64_strict_decoder_core.sv
tb/sv/tb_base64_strict_decoder_core.sv
